FILE: sv/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the clipped tile blitter
// Holds input modes, register indexes, coordinate widths and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ctb_pkg;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_LOAD        = 2'd0,
    MODE_DRAW_OPAQUE = 2'd1,
    MODE_DRAW_KEY    = 2'd2
  } mode_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 1'd1;

  localparam int DIM_REG_W = 4;
  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  // Payload widths fixed by the interface.
  localparam int TILE_IDX_W = 8;
  localparam int OFFSET_W   = 6;
  localparam int PIXEL_W    = 8;
  localparam int POS_W      = 16;
  localparam int DEST_W     = 16;

  // Screen positions carry one extra bit so that pos + 7 never wraps.
  localparam int COORD_W     = POS_W + 1;
  // Screen dimensions are at most 1024, so an on-screen coordinate fits here.
  localparam int SCR_IDX_W   = 10;
  localparam int FULL_ADDR_W = 2 * SCR_IDX_W + 1;

  localparam logic [PIXEL_W-1:0] PIXEL_CLEAR = 8'h00;

  typedef struct packed {
    logic capture;     // an input request is taken this cycle
    logic load_write;  // write the captured pixel into the tile RAM
    logic issue;       // read one tile pixel and step the scan
    logic row_end;     // the issued pixel closes a tile row
    logic last;        // the issued pixel closes the tile
  } cmd_t;

  typedef struct packed {
    logic issue_ok;    // room downstream for one more pixel
  } status_t;

endpackage

FILE: sv/clipped_tile_blitter_unit.sv
// ----------------------------------------------------------------------------
// clipped_tile_blitter_unit: tile store with a clipped, color-keyed draw scan
// Loads tiles pixel by pixel and draws a tile at a signed screen position,
// giving one framebuffer write request per tile pixel.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    mode, tile_index, load_offset, load_pixel,
//                                   pos_x, pos_y
//   out      out_valid / out_ready  dest_address, pixel_value, write_enable,
//                                   last_pixel
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load request writes the tile RAM from the load state; an ignored
// request leaves the controller idle. A draw request gives one pixel per
// cycle while out_ready is held high, set by the single port of the tile
// RAM. Each pixel passes the read stage and then the output queue.
// A low out_ready stalls the scan; a two-entry output queue keeps the rate.
// Reset sets both tile sizes to 8; the tile RAM is not cleared.
// ----------------------------------------------------------------------------
module clipped_tile_blitter_unit #(
  parameter int TILE_COUNT   = 256,
  parameter int MAX_TILE_DIM = 8,
  parameter int SCREEN_W     = 320,
  parameter int SCREEN_H     = 200
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [ctb_pkg::TILE_IDX_W-1:0]    tile_index,
  input  logic [ctb_pkg::OFFSET_W-1:0]      load_offset,
  input  logic [ctb_pkg::PIXEL_W-1:0]       load_pixel,
  input  logic signed [ctb_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ctb_pkg::POS_W-1:0]  pos_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ctb_pkg::DEST_W-1:0]        dest_address,
  output logic [ctb_pkg::PIXEL_W-1:0]       pixel_value,
  output logic                              write_enable,
  output logic                              last_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctb_pkg::DIM_REG_W-1:0]     cfg_data
);
  import ctb_pkg::*;

  cmd_t    cmd;
  status_t status;

  ctb_ctrl #(
    .MAX_TILE_DIM (MAX_TILE_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  ctb_datapath #(
    .TILE_COUNT   (TILE_COUNT),
    .MAX_TILE_DIM (MAX_TILE_DIM),
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .tile_index   (tile_index),
    .load_offset  (load_offset),
    .load_pixel   (load_pixel),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dest_address (dest_address),
    .pixel_value  (pixel_value),
    .write_enable (write_enable),
    .last_pixel   (last_pixel)
  );

endmodule

FILE: sv/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl: controller of the clipped tile blitter
// Holds the tile size registers, the request state machine and the row and
// column counters of the scan, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ctb_ctrl #(
  parameter int MAX_TILE_DIM = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctb_pkg::DIM_REG_W-1:0]    cfg_data,
  input  ctb_pkg::status_t                 status,
  output ctb_pkg::cmd_t                    cmd
);
  import ctb_pkg::*;

  localparam int DW = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_t;

  state_t                 state;
  logic [DIM_REG_W-1:0]   tile_width;
  logic [DIM_REG_W-1:0]   tile_height;
  logic [DIM_REG_W-1:0]   w_eff;
  logic [DIM_REG_W-1:0]   h_eff;
  logic [DW-1:0]          col;
  logic [DW-1:0]          row;
  logic                   accept;
  logic                   col_end;
  logic                   row_last;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // A size of zero acts as one, and sizes above the maximum are clamped.
  always_comb begin
    if (tile_width == '0) begin
      w_eff = DIM_REG_W'(1);
    end else if (tile_width > DIM_REG_W'(MAX_TILE_DIM)) begin
      w_eff = DIM_REG_W'(MAX_TILE_DIM);
    end else begin
      w_eff = tile_width;
    end
    if (tile_height == '0) begin
      h_eff = DIM_REG_W'(1);
    end else if (tile_height > DIM_REG_W'(MAX_TILE_DIM)) begin
      h_eff = DIM_REG_W'(MAX_TILE_DIM);
    end else begin
      h_eff = tile_height;
    end
  end

  assign col_end  = (col == DW'(w_eff - DIM_REG_W'(1)));
  assign row_last = (row == DW'(h_eff - DIM_REG_W'(1)));

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.load_write = (state == ST_LOAD);
    cmd.issue      = (state == ST_SCAN) && status.issue_ok;
    cmd.row_end    = col_end;
    cmd.last       = col_end && row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tile_width  <= DIM_RESET;
      tile_height <= DIM_RESET;
      col         <= '0;
      row         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TILE_WIDTH:  tile_width  <= cfg_data;
          CFG_TILE_HEIGHT: tile_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            col <= '0;
            row <= '0;
            case (mode)
              MODE_LOAD:                     state <= ST_LOAD;
              MODE_DRAW_OPAQUE, MODE_DRAW_KEY: state <= ST_SCAN;
              default:                       state <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD: begin
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (cmd.issue) begin
            if (col_end) begin
              col <= '0;
              row <= row + DW'(1);
              if (row_last) begin
                state <= ST_IDLE;
              end
            end else begin
              col <= col + DW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_closes_row: assert property (@(posedge clk) disable iff (rst)
    cmd.last |-> cmd.row_end)
    else $error("last pixel issued without a row end");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.last |=> in_ready)
    else $error("controller did not return to idle after the last pixel");
  a_no_issue_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !in_ready)
    else $error("pixel issued while taking new requests");
`endif

endmodule

FILE: sv/ctb_datapath.sv
// ----------------------------------------------------------------------------
// ctb_datapath: datapath of the clipped tile blitter
// Tile RAM, captured request fields, screen coordinate stepping, clipping,
// a one-stage read pipeline and a two-entry output queue.
// ----------------------------------------------------------------------------
module ctb_datapath #(
  parameter int TILE_COUNT   = 256,
  parameter int MAX_TILE_DIM = 8,
  parameter int SCREEN_W     = 320,
  parameter int SCREEN_H     = 200
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        mode,
  input  logic [ctb_pkg::TILE_IDX_W-1:0]    tile_index,
  input  logic [ctb_pkg::OFFSET_W-1:0]      load_offset,
  input  logic [ctb_pkg::PIXEL_W-1:0]       load_pixel,
  input  logic signed [ctb_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ctb_pkg::POS_W-1:0]  pos_y,
  input  ctb_pkg::cmd_t                     cmd,
  output ctb_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ctb_pkg::DEST_W-1:0]        dest_address,
  output logic [ctb_pkg::PIXEL_W-1:0]       pixel_value,
  output logic                              write_enable,
  output logic                              last_pixel
);
  import ctb_pkg::*;

  localparam int SLOT   = MAX_TILE_DIM * MAX_TILE_DIM;
  localparam int DEPTH  = TILE_COUNT * SLOT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int OFFW   = (SLOT > 1) ? $clog2(SLOT) : 1;
  localparam int NTILE  = 1 << TILE_IDX_W;
  localparam int QDEPTH = 2;

  // Tile index reduced modulo the tile count, as a constant table.
  logic [TW-1:0] tile_mod [NTILE];
  for (genvar i = 0; i < NTILE; i++) begin : g_tile_mod
    assign tile_mod[i] = TW'(i % TILE_COUNT);
  end

  logic [PIXEL_W-1:0]         mem [DEPTH];
  logic [PIXEL_W-1:0]         rdata;
  logic [AW-1:0]              base;
  logic [AW-1:0]              mem_addr;
  logic [OFFSET_W-1:0]        offset_reg;
  logic [PIXEL_W-1:0]         pixel_reg;
  logic                       key_mode;
  logic [OFFW-1:0]            pix_cnt;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  sx;
  logic signed [COORD_W-1:0]  sy;
  logic                       load_ok;
  logic                       on_screen;
  logic [FULL_ADDR_W-1:0]     full_addr;
  logic [DEST_W-1:0]          a_addr;

  logic                       b_valid;
  logic [DEST_W-1:0]          b_addr;
  logic                       b_on;
  logic                       b_key;
  logic                       b_last;
  logic                       b_en;

  logic [DEST_W-1:0]          q_addr [QDEPTH];
  logic [PIXEL_W-1:0]         q_pix  [QDEPTH];
  logic                       q_en   [QDEPTH];
  logic                       q_last [QDEPTH];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 count;
  logic                       pop;
  logic [2:0]                 in_flight;

  assign load_ok  = {1'b0, offset_reg} < (OFFSET_W + 1)'(SLOT);
  assign mem_addr = base + (cmd.load_write ? AW'(offset_reg) : AW'(pix_cnt));

  // Clipping and the framebuffer address of the pixel being issued.
  assign on_screen = !sx[COORD_W-1] && (sx[POS_W-1:0] < POS_W'(SCREEN_W)) &&
                     !sy[COORD_W-1] && (sy[POS_W-1:0] < POS_W'(SCREEN_H));
  assign full_addr = FULL_ADDR_W'(sy[SCR_IDX_W-1:0]) * FULL_ADDR_W'(SCREEN_W) +
                     FULL_ADDR_W'(sx[SCR_IDX_W-1:0]);
  assign a_addr    = on_screen ? full_addr[DEST_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      base       <= AW'(tile_mod[tile_index]) * AW'(SLOT);
      offset_reg <= load_offset;
      pixel_reg  <= load_pixel;
      key_mode   <= (mode == MODE_DRAW_KEY);
      pix_cnt    <= '0;
      px         <= COORD_W'(pos_x);
      sx         <= COORD_W'(pos_x);
      sy         <= COORD_W'(pos_y);
    end else if (cmd.issue) begin
      pix_cnt <= pix_cnt + OFFW'(1);
      if (cmd.row_end) begin
        sx <= px;
        sy <= sy + COORD_W'(1);
      end else begin
        sx <= sx + COORD_W'(1);
      end
    end
  end

  // Tile RAM: one port, written on loads and read during a scan.
  always_ff @(posedge clk) begin
    if (cmd.load_write && load_ok) begin
      mem[mem_addr] <= pixel_reg;
    end
    if (cmd.issue) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= cmd.issue;
    end
    if (cmd.issue) begin
      b_addr <= a_addr;
      b_on   <= on_screen;
      b_key  <= key_mode;
      b_last <= cmd.last;
    end
  end

  assign b_en = b_on && !(b_key && (rdata == PIXEL_CLEAR));

  // Output queue. A pixel may be issued only if the queue can still hold it
  // when it leaves the read stage, counting the one already in the read stage.
  assign pop             = out_valid && out_ready;
  assign in_flight       = 3'(count) + 3'(b_valid) - 3'(pop);
  assign status.issue_ok = in_flight < 3'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (b_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(b_valid) - 2'(pop);
    end
    if (b_valid) begin
      q_addr[wr_ptr] <= b_addr;
      q_pix[wr_ptr]  <= rdata;
      q_en[wr_ptr]   <= b_en;
      q_last[wr_ptr] <= b_last;
    end
  end

  assign out_valid    = (count != '0);
  assign dest_address = q_addr[rd_ptr];
  assign pixel_value  = q_pix[rd_ptr];
  assign write_enable = q_en[rd_ptr];
  assign last_pixel   = q_last[rd_ptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b_valid && !pop |-> count != 2'(QDEPTH))
    else $error("pixel pushed into a full output queue");
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.issue && cmd.load_write))
    else $error("tile RAM read and write in the same cycle");
  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> b_valid)
    else $error("issued pixel missing from the read stage");
`endif

endmodule

FILE: test/tile_draw_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_draw_monitor: watches the blitter channels and checks every pixel
// Keeps its own copy of the tile store and the tile size registers. Each
// accepted draw request is expanded into the pixel writes it must produce.
// Those are compared field by field, in order, with the results that leave
// the block.
// ----------------------------------------------------------------------------
module tile_draw_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic [ctb_pkg::TILE_IDX_W-1:0]   tile_index,
  input  logic [ctb_pkg::OFFSET_W-1:0]     load_offset,
  input  logic [ctb_pkg::PIXEL_W-1:0]      load_pixel,
  input  logic signed [ctb_pkg::POS_W-1:0] pos_x,
  input  logic signed [ctb_pkg::POS_W-1:0] pos_y,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [ctb_pkg::DEST_W-1:0]       dest_address,
  input  logic [ctb_pkg::PIXEL_W-1:0]      pixel_value,
  input  logic                             write_enable,
  input  logic                             last_pixel,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctb_pkg::DIM_REG_W-1:0]    cfg_data,
  output int                               fail_count,
  output int                               pending_pixels
);
  import ctb_pkg::*;

  localparam int SCREEN_W     = 320;
  localparam int SCREEN_H     = 200;
  localparam int MAX_DIM      = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DEST_W-1:0]  addr;
    logic [PIXEL_W-1:0] value;
    logic               we;
    logic               last;
  } blit_pixel_t;

  logic [PIXEL_W-1:0]   tile_mem [0:(1 << (TILE_IDX_W + OFFSET_W)) - 1];
  logic [DIM_REG_W-1:0] width_reg;
  logic [DIM_REG_W-1:0] height_reg;
  blit_pixel_t          expected_pixels [$];
  int                   result_seq;

  function automatic int clamp_dim(input logic [DIM_REG_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  // Expand one draw request into its pixel writes, row by row.
  task automatic queue_draw(input logic key, input logic [TILE_IDX_W-1:0] tile,
                            input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y);
    int          w;
    int          h;
    int          sx;
    int          sy;
    logic        visible;
    blit_pixel_t px;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        // Screen coordinates are exact; no 16-bit wrap back onto the screen.
        sx = int'(x) + c;
        sy = int'(y) + r;
        visible  = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
        px.value = tile_mem[{tile, OFFSET_W'(r * w + c)}];
        px.addr  = visible ? DEST_W'(sx + sy * SCREEN_W) : '0;
        px.we    = visible && !(key && px.value == PIXEL_CLEAR);
        px.last  = (r == h - 1) && (c == w - 1);
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic check_result();
    blit_pixel_t got;
    blit_pixel_t want;
    got = {dest_address, pixel_value, write_enable, last_pixel};
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: result %0d with no draw pending: addr=%0d pixel=%02h we=%0b last=%0b",
                 $time, result_seq, got.addr, got.value, got.we, got.last);
    end else begin
      want = expected_pixels.pop_front();
      if (got.addr !== want.addr || got.value !== want.value ||
          got.we !== want.we || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display({"%0t: result %0d mismatch: expected addr=%0d pixel=%02h we=%0b last=%0b,",
                    " got addr=%0d pixel=%02h we=%0b last=%0b"},
                   $time, result_seq, want.addr, want.value, want.we, want.last,
                   got.addr, got.value, got.we, got.last);
      end
    end
    result_seq++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      expected_pixels.delete();
      result_seq = 0;
      fail_count = 0;
      pending_pixels <= 0;
    end else begin
      // Results are checked before a new request is expanded, so a request
      // taken in this cycle can never satisfy a result leaving in it.
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TILE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_TILE_HEIGHT) height_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (mode)
          MODE_LOAD:                     tile_mem[{tile_index, load_offset}] = load_pixel;
          MODE_DRAW_OPAQUE, MODE_DRAW_KEY:
            queue_draw(mode == MODE_DRAW_KEY, tile_index, pos_x, pos_y);
          default: ;
        endcase
      end
      pending_pixels <= expected_pixels.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level test of the clipped tile blitter
// Loads tiles and draws them at positions on, across and far outside the
// screen, in opaque and color-keyed modes, under several tile sizes. The
// monitor beside the block checks each pixel; this module only makes the
// requests, applies back pressure and reports the outcome.
// ----------------------------------------------------------------------------
module tb;
  import ctb_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         MAX_DIM       = 8;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         REGIME_ITEMS  = 157;
  localparam int         PHASES        = 7;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               mode;
  logic [TILE_IDX_W-1:0]    tile_index;
  logic [OFFSET_W-1:0]      load_offset;
  logic [PIXEL_W-1:0]       load_pixel;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DEST_W-1:0]        dest_address;
  logic [PIXEL_W-1:0]       pixel_value;
  logic                     write_enable;
  logic                     last_pixel;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DIM_REG_W-1:0]     cfg_data;

  int fail_count;
  int pending_pixels;
  int send_idle_pct = 31;
  int recv_idle_pct = 62;
  int sent_items    = 0;
  int cycle_count   = 0;
  int draw_area     = MAX_DIM * MAX_DIM;

  // Store entries written so far; a draw only reads a fully written area.
  bit loaded [0:(1 << (TILE_IDX_W + OFFSET_W)) - 1];
  int seq_tiles [$];

  logic [DIM_REG_W-1:0] phase_w [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd8, 4'd8};
  logic [DIM_REG_W-1:0] phase_h [PHASES] = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd5, 4'd8, 4'd8};
  int                   phase_budget [PHASES] = '{90, 55, 55, 45, 60, 60, 80};

  clipped_tile_blitter_unit dut (.*);

  tile_draw_monitor draw_mon (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic int effective_dim(input logic [DIM_REG_W-1:0] raw);
    return (raw < 1) ? 1 : (raw > MAX_DIM) ? MAX_DIM : int'(raw);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    return ($urandom_range(9) < 3) ? PIXEL_CLEAR : PIXEL_W'($urandom_range(255));
  endfunction

  // Valid stays high from one request to the next unless the sender idles.
  task automatic send_req(input logic [1:0] op, input logic [TILE_IDX_W-1:0] tile,
                          input logic [OFFSET_W-1:0] ofs, input logic [PIXEL_W-1:0] pix,
                          input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    if (sent_items >= 2 * REGIME_ITEMS) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (sent_items >= REGIME_ITEMS) begin
      send_idle_pct = 62;
      recv_idle_pct = 31;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    mode        <= op;
    tile_index  <= tile;
    load_offset <= ofs;
    load_pixel  <= pix;
    pos_x       <= x;
    pos_y       <= y;
    do @(posedge clk); while (!in_ready);
    if (op == MODE_LOAD) loaded[{tile, ofs}] = 1'b1;
    if (op != MODE_UNUSED) sent_items++;
  endtask

  // Hold off new requests until every pixel has left and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tile_size(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TILE_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TILE_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    draw_area = effective_dim(w) * effective_dim(h);
  endtask

  initial begin
    int                      phase_end;
    int                      pick;
    logic [TILE_IDX_W-1:0]   tile;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;

    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_LOAD;
    tile_index  = '0;
    load_offset = '0;
    load_pixel  = '0;
    pos_x       = '0;
    pos_y       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_TILE_WIDTH;
    cfg_data    = '0;
    phase_w[5]  = DIM_REG_W'($urandom_range(15));
    phase_h[5]  = DIM_REG_W'($urandom_range(15));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on 2x2 tiles: field extremes, both draw modes, clipping on
    // every side, positions at the ends of the signed range.
    set_tile_size(4'd2, 4'd2);
    send_req(MODE_LOAD, 8'd0, 6'd0, 8'h00, rand16(), rand16());
    send_req(MODE_LOAD, 8'd0, 6'd1, 8'hFF, rand16(), rand16());
    send_req(MODE_LOAD, 8'd0, 6'd2, 8'h5A, rand16(), rand16());
    send_req(MODE_LOAD, 8'd0, 6'd3, 8'h00, rand16(), rand16());
    send_req(MODE_LOAD, 8'd255, 6'd0, 8'h81, rand16(), rand16());
    send_req(MODE_LOAD, 8'd255, 6'd1, 8'h00, rand16(), rand16());
    send_req(MODE_LOAD, 8'd255, 6'd2, 8'h7E, rand16(), rand16());
    send_req(MODE_LOAD, 8'd255, 6'd3, 8'h01, rand16(), rand16());
    // Stored outside the drawn area, so it must never show up.
    send_req(MODE_LOAD, 8'd255, 6'd63, 8'hFF, rand16(), rand16());
    // The unused mode must leave the store untouched.
    send_req(MODE_UNUSED, 8'd255, 6'd0, 8'h00, 16'h0000, 16'h0000);
    send_req(MODE_DRAW_OPAQUE, 8'd0, 6'd63, 8'hFF, 16'd0, 16'd0);
    send_req(MODE_DRAW_KEY, 8'd0, 6'd0, 8'h00, 16'd0, 16'd0);
    send_req(MODE_DRAW_KEY, 8'd0, 6'd0, 8'h00, 16'd318, 16'd198);
    send_req(MODE_DRAW_OPAQUE, 8'd0, 6'd0, 8'h00, 16'd319, 16'd199);
    send_req(MODE_DRAW_KEY, 8'd255, 6'd0, 8'h00, 16'hFFFF, 16'hFFFF);
    send_req(MODE_DRAW_OPAQUE, 8'd255, 6'd0, 8'h00, 16'h8000, 16'h8000);
    send_req(MODE_DRAW_OPAQUE, 8'd255, 6'd0, 8'h00, 16'h7FFF, 16'h7FFF);
    send_req(MODE_DRAW_KEY, 8'd0, 6'd0, 8'h00, 16'h7FFF, 16'h8000);
    send_req(MODE_DRAW_OPAQUE, 8'd0, 6'd0, 8'h00, 16'h8000, 16'h7FFF);
    send_req(MODE_DRAW_OPAQUE, 8'd255, 6'd0, 8'h00, 16'hFFFE, 16'd100);
    send_req(MODE_DRAW_KEY, 8'd255, 6'd0, 8'h00, 16'd100, 16'd199);
    send_req(MODE_DRAW_OPAQUE, 8'd255, 6'd0, 8'h00, 16'd320, 16'd0);
    send_req(MODE_DRAW_KEY, 8'd0, 6'd0, 8'h00, 16'd0, 16'd200);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_tile_size(phase_w[p], phase_h[p]);
      phase_end = sent_items + phase_budget[p];
      while (sent_items < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Noise: an ignored request or a stray load anywhere in the store.
          if ($urandom_range(1))
            send_req(MODE_UNUSED, 8'($urandom), 6'($urandom), 8'($urandom),
                     rand16(), rand16());
          else
            send_req(MODE_LOAD, 8'($urandom), 6'($urandom), rand_pixel(),
                     rand16(), rand16());
        end else if (pick < 11) begin
          drain();
        end else begin
          // Fill whatever the current size still lacks, then draw the tile.
          if (seq_tiles.size() > 0 && $urandom_range(1)) begin
            tile = 8'(seq_tiles[$urandom_range(seq_tiles.size() - 1)]);
          end else begin
            tile = 8'($urandom_range(255));
            seq_tiles.push_back(int'(tile));
          end
          for (int k = 0; k < draw_area; k++)
            if (!loaded[{tile, 6'(k)}])
              send_req(MODE_LOAD, tile, 6'(k), rand_pixel(), rand16(), rand16());
          repeat ($urandom_range(2))
            send_req(MODE_LOAD, tile, 6'($urandom_range(draw_area - 1)), rand_pixel(),
                     rand16(), rand16());
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
              0, 1: begin
                x = 16'(int'($urandom_range(329)) - 10);
                y = 16'(int'($urandom_range(209)) - 10);
              end
              2: begin
                x = $urandom_range(1) ? 16'(int'($urandom_range(8)) - 8)
                                      : 16'(312 + $urandom_range(8));
                y = $urandom_range(1) ? 16'(int'($urandom_range(8)) - 8)
                                      : 16'(192 + $urandom_range(8));
              end
              default: begin
                x = rand16();
                y = rand16();
              end
            endcase
            send_req($urandom_range(1) ? MODE_DRAW_OPAQUE : MODE_DRAW_KEY, tile,
                     6'($urandom), 8'($urandom), x, y);
          end
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ctb_pkg.sv
sv/ctb_ctrl.sv
sv/ctb_datapath.sv
sv/clipped_tile_blitter_unit.sv
test/tile_draw_monitor.sv
test/tb.sv
